// File: sv/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// shared types and codes for the periodic event scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package pes_pkg;
  localparam int unsigned MaxUsersDef = 64;
  localparam int unsigned MaxBurstDef = 64;
  localparam int unsigned IdW = 16;
  localparam int unsigned PerW = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned CntW = 7;
  localparam int unsigned StatW = 3;
  localparam int unsigned EntW = IdW + PerW + TimeW;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_EMIT = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [StatW-1:0] ST_EVENT = 3'd0;
  localparam logic [StatW-1:0] ST_ADDED = 3'd1;
  localparam logic [StatW-1:0] ST_FULL = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY = 3'd3;
  localparam logic [StatW-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [TimeW-1:0] due;
    logic [IdW-1:0]   id;
    logic [PerW-1:0]  per;
  } entry_t;

  // strict order: smaller due, then id, then period
  function automatic logic earlier(input entry_t a, input entry_t b);
    earlier = (a.due != b.due) ? (a.due < b.due) :
              (a.id != b.id) ? (a.id < b.id) : (a.per < b.per);
  endfunction
endpackage
`default_nettype wire

// File: sv/pes_ram.sv
// ----------------------------------------------------------------------------
// pes_ram
// generic dual port ram (separate write and read address) with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module pes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/pes_heap.sv
// ----------------------------------------------------------------------------
// pes_heap
// binary min heap over one ram: push (sift up) and replace-top (sift down)
// ----------------------------------------------------------------------------
`default_nettype none
module pes_heap
  import pes_pkg::*;
#(
  parameter int unsigned MaxUsers = MaxUsersDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic                       repl_i,
  input  wire logic                       clear_i,
  input  pes_pkg::entry_t                 ent_i,
  output logic                            busy_o,
  output pes_pkg::entry_t                 top_o,
  output logic [$clog2(MaxUsers+1)-1:0]   count_o
);
  localparam int unsigned AW = $clog2(MaxUsers);
  localparam int unsigned CW = $clog2(MaxUsers+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP_RD = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DN_RDL = 3'd3;
  localparam logic [2:0] S_DN_RDR = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;     // hole index
  entry_t cur_q, cur_d;            // value being placed
  entry_t top_q, top_d;
  entry_t lch_q, lch_d;
  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [CW:0] lidx, ridx;
  logic [CW-1:0] par;

  pes_ram #(.Width(EntW), .Depth(MaxUsers)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign lidx = {pos_q, 1'b0} + {{CW{1'b0}}, 1'b1};
  assign ridx = lidx + {{CW{1'b0}}, 1'b1};
  assign par = (pos_q - CW'(1)) >> 1;
  assign busy_o = (state_q != S_IDLE);
  assign top_o = top_q;
  assign count_o = count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d = pos_q;
    cur_d = cur_q;
    top_d = top_q;
    lch_d = lch_q;
    we = 1'b0;
    waddr = pos_q[AW-1:0];
    wdata = cur_q;
    raddr = par[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (clear_i) begin
          count_d = '0;
        end else if (push_i) begin
          cur_d = ent_i;
          pos_d = count_q;
          count_d = count_q + CW'(1);
          if (count_q == '0) begin
            top_d = ent_i;
            we = 1'b1;
            waddr = '0;
            wdata = ent_i;
          end else begin
            state_d = S_UP_RD;
          end
        end else if (repl_i) begin
          cur_d = ent_i;
          pos_d = '0;
          state_d = S_DN_RDL;
        end
      end
      S_UP_RD: begin
        // hole reached the root: place the value there
        if (pos_q == '0) begin
          we = 1'b1;
          top_d = cur_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_UP_CMP;   // parent read issued
        end
      end
      S_UP_CMP: begin
        if (earlier(cur_q, rdata)) begin
          we = 1'b1;
          wdata = rdata;              // move parent down into the hole
          pos_d = par;
          state_d = S_UP_RD;
        end else begin
          we = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_RDL: begin
        if (lidx >= {1'b0, count_q}) begin
          we = 1'b1;
          state_d = S_IDLE;
          if (pos_q == '0) top_d = cur_q;
        end else begin
          raddr = lidx[AW-1:0];
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lch_d = rdata;
        raddr = ridx[AW-1:0];
        state_d = S_DN_CMP;
      end
      default: begin // S_DN_CMP, rdata is right child when it exists
        if (ridx < {1'b0, count_q} && earlier(rdata, lch_q)) begin
          if (earlier(rdata, cur_q)) begin
            we = 1'b1; wdata = rdata;
            if (pos_q == '0) top_d = rdata;
            pos_d = ridx[CW-1:0];
            state_d = S_DN_RDL;
          end else begin
            we = 1'b1;
            if (pos_q == '0) top_d = cur_q;
            state_d = S_IDLE;
          end
        end else if (earlier(lch_q, cur_q)) begin
          we = 1'b1; wdata = lch_q;
          if (pos_q == '0) top_d = lch_q;
          pos_d = lidx[CW-1:0];
          state_d = S_DN_RDL;
        end else begin
          we = 1'b1;
          if (pos_q == '0) top_d = cur_q;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    top_q <= top_d;
    lch_q <= lch_d;
  end
endmodule
`default_nettype wire

// File: sv/periodic_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_event_scheduler_core
// periodic users held in a ram min heap; emit pops and reschedules in order
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low first)              tuser / tlast
//  s_axis   in   user_id, period, event_count          kind / -
//  m_axis   out  event_user, event_time                status / last
//
// clear resets the heap count directly; an add sifts up with a parent read and
// a compare per level, then writes the value into the hole or the root.
// each event issues a replace-top walk that reads the left and right child and
// compares per level moved, then writes the value where it stops.
// no clearing pass after reset is needed, the heap count bounds every use of read data.
// one request is worked at a time; a waiting result holds off input and the
// next event.
`default_nettype none
module periodic_event_scheduler_core
  import pes_pkg::*;
#(
  parameter int unsigned MaxUsers = MaxUsersDef,
  parameter int unsigned MaxBurst = MaxBurstDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // user_id, period, event_count
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // event_user, event_time
  output logic [2:0]       m_axis_tuser,  // status
  output logic             m_axis_tlast
);
  localparam int unsigned CW = $clog2(MaxUsers+1);

  logic push, repl, clr, hbusy;
  entry_t hin, top;
  logic [CW-1:0] cnt;
  logic [CntW-1:0] left_q;
  logic emit_q;
  logic ov_q;
  logic [63:0] od_q;
  logic [2:0] ou_q;
  logic ol_q;
  logic [CntW-1:0] n_req;
  logic [TimeW:0] sum;
  logic acc, gen, out_free;

  pes_heap #(.MaxUsers(MaxUsers)) u_heap (
    .clk_i, .rst_ni, .push_i(push), .repl_i(repl), .clear_i(clr),
    .ent_i(hin), .busy_o(hbusy), .top_o(top), .count_o(cnt)
  );

  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = !emit_q && !hbusy && out_free;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign gen = emit_q && !hbusy && out_free;
  assign sum = {1'b0, top.due} + {{(TimeW+1-PerW){1'b0}}, top.per};
  assign n_req = (s_axis_tdata[38:32] == '0) ? CntW'(1) :
                 (s_axis_tdata[38:32] > CntW'(MaxBurst)) ? CntW'(MaxBurst) :
                 s_axis_tdata[38:32];

  always_comb begin
    push = 1'b0; repl = 1'b0; clr = 1'b0;
    hin = '{due: TimeW'(s_axis_tdata[31:16]), id: s_axis_tdata[15:0],
            per: s_axis_tdata[31:16]};
    if (acc && s_axis_tuser == KIND_ADD && cnt < CW'(MaxUsers)) push = 1'b1;
    if (acc && s_axis_tuser == KIND_CLEAR) clr = 1'b1;
    if (gen) begin
      repl = 1'b1;
      hin = '{due: sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0],
              id: top.id, per: top.per};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      emit_q <= 1'b0;
      left_q <= '0;
    end else begin
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      if (acc) begin
        unique case (s_axis_tuser)
          KIND_ADD: ov_q <= 1'b1;
          KIND_CLEAR: ov_q <= 1'b1;
          KIND_EMIT: begin
            if (cnt == '0) ov_q <= 1'b1;
            else begin
              emit_q <= 1'b1;
              left_q <= n_req;
            end
          end
          default: ;
        endcase
      end
      if (gen) begin
        ov_q <= 1'b1;
        left_q <= left_q - CntW'(1);
        if (left_q == CntW'(1)) emit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      od_q <= '0;
      ol_q <= 1'b1;
      ou_q <= (s_axis_tuser == KIND_ADD) ?
                ((cnt < CW'(MaxUsers)) ? ST_ADDED : ST_FULL) :
              (s_axis_tuser == KIND_CLEAR) ? ST_CLEARED : ST_EMPTY;
    end
    if (gen) begin
      od_q <= {top.due, top.id};
      ou_q <= ST_EVENT;
      ol_q <= (left_q == CntW'(1));
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = od_q;
  assign m_axis_tuser = ou_q;
  assign m_axis_tlast = ol_q;
endmodule
`default_nettype wire
